>>> hw/rtl/wrcc_pkg.sv
`default_nettype none
package wrcc_pkg;

    localparam int RATIO_W = 17;
    localparam int CV_W    = 24;
    localparam int CNT_W   = 32;

    localparam logic [1:0] STATUS_NOT_FULL  = 2'd0;
    localparam logic [1:0] STATUS_MEAN_ZERO = 2'd1;
    localparam logic [1:0] STATUS_VALID     = 2'd2;

    localparam logic CFG_WINDOW_LENGTH = 1'b0;
    localparam logic CFG_CV_THRESHOLD  = 1'b1;

    localparam logic [6:0]      WL_RESET  = 7'd64;
    localparam logic [CV_W-1:0] THR_RESET = 24'd655;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDIV,
        S_WRITE,
        S_ACC,
        S_MUL,
        S_SUB,
        S_QDIV,
        S_SQRT,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

>>> hw/rtl/wrcc_ram.sv
`default_nettype none
module wrcc_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int W     = 17
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/wrcc_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle; dividend comes left-aligned
module wrcc_div #(
    parameter int NW = 80,
    parameter int VW = 48,
    parameter int CW = 7
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [VW-1:0] i_den,
    input  wire logic [CW-1:0] i_steps,
    output logic               o_busy,
    output logic      [NW-1:0] o_quot
);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_acc;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_den;
    logic [VW:0]   rem2;
    logic [VW:0]   rem_sub;
    logic          ge;

    always_comb begin
        rem2    = {r_rem, r_acc[NW-1]};
        ge      = rem2 >= {1'b0, r_den};
        rem_sub = ge ? rem2 - {1'b0, r_den} : rem2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_acc <= {r_acc[NW-2:0], ge};
            r_rem <= rem_sub[VW-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_acc;

endmodule
`default_nettype wire

>>> hw/rtl/wrcc_sqrt.sv
`default_nettype none
// digit-by-digit integer square root, two radicand bits per cycle
module wrcc_sqrt #(
    parameter int XW = 40
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [XW-1:0]     i_x,
    output logic                   o_busy,
    output logic      [XW/2-1:0]   o_root
);

    logic [XW-1:0] r_x;
    logic [XW-1:0] r_res;
    logic [XW-1:0] r_bit;
    logic [XW-1:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= '0;
        end else if (i_start) begin
            r_bit <= XW'(1) << (XW - 2);
        end else begin
            r_bit <= r_bit >> 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_res <= '0;
        end else if (r_bit != '0) begin
            if (r_x >= trial) begin
                r_x   <= r_x - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
        end
    end

    assign o_busy = r_bit != '0;
    assign o_root = r_res[XW/2-1:0];

endmodule
`default_nettype wire

>>> hw/rtl/window_ratio_convergence_check_unit.sv
`default_nettype none
// Flow: while the window fills, an input beat passes the ratio divide and the window write
// to o_out_valid; with a full window of n entries it then walks the window, does the std/mean
// divide and the square root, with control states in between.
// Items are handled one at a time: the next beat is taken once the result is registered,
// so any output stall also holds off the input.
// Reset (synchronous, active low) empties the window, clears the converged flag and
// restores window_length=64, cv_threshold=655. Window RAM contents are not cleared.
module window_ratio_convergence_check_unit #(
    parameter int WINDOW_MAX = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [23:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_bound_count,
    input  wire logic [31:0] i_exited_count,
    input  wire logic [31:0] i_timeout_count,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic [23:0]      o_cv_ratio,
    output logic [16:0]      o_newest_ratio,
    output logic             o_converged
);

    localparam int AW    = $clog2(WINDOW_MAX);
    localparam int LW    = $clog2(WINDOW_MAX + 1);
    localparam int SUMW  = 17 + LW;
    localparam int SQW   = 34 + LW;
    localparam int S2W   = 2 * SUMW;
    localparam int DW    = SQW + LW;
    localparam int NW    = DW + 32;          // std/mean dividend d<<32
    localparam int VW    = S2W;
    localparam int CW    = $clog2(NW + 1);
    localparam int QW    = 32 + LW;
    localparam int SQRTW = QW + (QW % 2);
    localparam int RW    = SQRTW / 2;
    localparam int CXW   = (RW > 24) ? RW : 24;
    localparam int RNW   = 50;               // ratio dividend width
    localparam int RDW   = 35;               // ratio divisor width

    wrcc_pkg::t_state r_state, n_state;

    logic [6:0]     r_wl;
    logic [23:0]    r_thr;
    logic           r_zero, n_zero;
    logic [16:0]    r_ratio, n_ratio;
    logic [LW-1:0]  r_held, n_held;
    logic [AW-1:0]  r_wslot, n_wslot;
    logic [AW-1:0]  r_ridx, n_ridx;
    logic [LW-1:0]  r_issue, n_issue;
    logic           r_rv, n_rv;
    logic           r_pv, n_pv;
    logic [16:0]    r_pval, n_pval;
    logic [33:0]    r_prod, n_prod;
    logic [SUMW-1:0] r_sum, n_sum;
    logic [SQW-1:0] r_sq, n_sq;
    logic [S2W-1:0] r_s2, n_s2;
    logic [DW-1:0]  r_nq, n_nq;
    logic           r_latch, n_latch;
    logic [1:0]     r_pstatus, n_pstatus;
    logic [23:0]    r_pcv, n_pcv;
    logic           r_oval, n_oval;
    logic [1:0]     r_ostatus, n_ostatus;
    logic [23:0]    r_ocv, n_ocv;
    logic [16:0]    r_oratio, n_oratio;
    logic           r_oconv, n_oconv;

    logic [LW-1:0]  len;
    logic [LW:0]    held1;
    logic [33:0]    total;
    logic [AW-1:0]  wslot_nx;
    logic [AW-1:0]  rd_addr;
    logic [DW-1:0]  d_val;
    logic [CXW-1:0] root_x;
    logic [23:0]    cv;

    // shared divider / sqrt hookup
    logic           div_start;
    logic [NW-1:0]  div_num;
    logic [VW-1:0]  div_den;
    logic [CW-1:0]  div_steps;
    logic           div_busy;
    logic [NW-1:0]  div_quot;
    logic           sq_start;
    logic           sq_busy;
    logic [RW-1:0]  sq_root;

    logic           ram_we;
    logic           ram_re;
    logic [16:0]    ram_rdata;

    wrcc_ram #(.DEPTH(WINDOW_MAX), .AW(AW), .W(17)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wslot),
        .i_wdata (r_ratio),
        .i_re    (ram_re),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    wrcc_div #(.NW(NW), .VW(VW), .CW(CW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_steps (div_steps),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    wrcc_sqrt #(.XW(SQRTW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_x     (SQRTW'(div_quot[QW-1:0])),
        .o_busy  (sq_busy),
        .o_root  (sq_root)
    );

    // effective window length: 0 acts as 1, clamp at WINDOW_MAX
    always_comb begin
        if (r_wl == 7'd0) begin
            len = LW'(1);
        end else if (32'(r_wl) > WINDOW_MAX) begin
            len = LW'(WINDOW_MAX);
        end else begin
            len = LW'(r_wl);
        end
    end

    assign total    = 34'(i_bound_count) + 34'(i_exited_count) + 34'(i_timeout_count);
    assign held1    = {1'b0, r_held} + 1'b1;
    assign wslot_nx = (r_wslot == AW'(WINDOW_MAX - 1)) ? '0 : r_wslot + 1'b1;
    assign rd_addr  = (r_ridx == '0) ? AW'(WINDOW_MAX - 1) : r_ridx - 1'b1;
    assign d_val    = (r_nq >= DW'(r_s2)) ? r_nq - DW'(r_s2) : '0;
    assign root_x   = CXW'(sq_root);
    assign cv       = (root_x > CXW'(24'hFFFFFF)) ? 24'hFFFFFF : root_x[23:0];

    assign o_in_stall = r_state != wrcc_pkg::S_IDLE;

    always_comb begin
        n_state   = r_state;
        n_zero    = r_zero;
        n_ratio   = r_ratio;
        n_held    = r_held;
        n_wslot   = r_wslot;
        n_ridx    = r_ridx;
        n_issue   = r_issue;
        n_sum     = r_sum;
        n_sq      = r_sq;
        n_s2      = r_s2;
        n_nq      = r_nq;
        n_latch   = r_latch;
        n_pstatus = r_pstatus;
        n_pcv     = r_pcv;
        n_oval    = r_oval && i_out_stall;
        n_ostatus = r_ostatus;
        n_ocv     = r_ocv;
        n_oratio  = r_oratio;
        n_oconv   = r_oconv;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        div_start = 1'b0;
        // ratio divide: round(b*2^16/total) = ((b<<17)+total) / (total<<1)
        div_num   = {({1'b0, i_bound_count, 17'b0} + RNW'(total)), (NW - RNW)'(0)};
        div_den   = VW'({total, 1'b0});
        div_steps = CW'(RNW);
        sq_start  = 1'b0;

        unique case (r_state)
            wrcc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_zero    = total == '0;
                    div_start = 1'b1;
                    n_state   = wrcc_pkg::S_RDIV;
                end
            end
            wrcc_pkg::S_RDIV: begin
                if (!div_busy) begin
                    n_ratio = r_zero ? '0 : div_quot[16:0];
                    n_state = wrcc_pkg::S_WRITE;
                end
            end
            wrcc_pkg::S_WRITE: begin
                ram_we  = 1'b1;
                n_wslot = wslot_nx;
                n_ridx  = wslot_nx;
                n_issue = '0;
                n_sum   = '0;
                n_sq    = '0;
                if (held1 < {1'b0, len}) begin
                    n_held    = held1[LW-1:0];
                    n_pstatus = wrcc_pkg::STATUS_NOT_FULL;
                    n_pcv     = '0;
                    n_state   = wrcc_pkg::S_DONE;
                end else begin
                    n_held  = len;
                    n_state = wrcc_pkg::S_ACC;
                end
            end
            wrcc_pkg::S_ACC: begin
                // read newest to oldest; read -> square -> accumulate
                if (r_issue != r_held) begin
                    ram_re  = 1'b1;
                    n_ridx  = rd_addr;
                    n_issue = r_issue + 1'b1;
                end
                if (r_pv) begin
                    n_sum = r_sum + SUMW'(r_pval);
                    n_sq  = r_sq + SQW'(r_prod);
                end
                if (r_issue == r_held && !r_rv && !r_pv) begin
                    n_state = wrcc_pkg::S_MUL;
                end
            end
            wrcc_pkg::S_MUL: begin
                n_s2 = S2W'(r_sum) * S2W'(r_sum);
                n_nq = DW'(r_held) * DW'(r_sq);
                if (r_sum == '0) begin
                    n_pstatus = wrcc_pkg::STATUS_MEAN_ZERO;
                    n_pcv     = '0;
                    n_state   = wrcc_pkg::S_DONE;
                end else begin
                    n_state = wrcc_pkg::S_SUB;
                end
            end
            wrcc_pkg::S_SUB: begin
                // (n*Q - S^2) * 2^32 / S^2
                div_start = 1'b1;
                div_num   = {d_val, 32'b0};
                div_den   = r_s2;
                div_steps = CW'(NW);
                n_state   = wrcc_pkg::S_QDIV;
            end
            wrcc_pkg::S_QDIV: begin
                if (!div_busy) begin
                    sq_start = 1'b1;
                    n_state  = wrcc_pkg::S_SQRT;
                end
            end
            wrcc_pkg::S_SQRT: begin
                if (!sq_busy) begin
                    n_pstatus = wrcc_pkg::STATUS_VALID;
                    n_pcv     = cv;
                    if (cv != '0 && cv <= r_thr) begin
                        n_latch = 1'b1;
                    end
                    n_state = wrcc_pkg::S_DONE;
                end
            end
            wrcc_pkg::S_DONE: begin
                // flag is captured with the beat so a held result keeps its value
                if (!r_oval || !i_out_stall) begin
                    n_oval    = 1'b1;
                    n_ostatus = r_pstatus;
                    n_ocv     = r_pcv;
                    n_oratio  = r_ratio;
                    n_oconv   = r_latch;
                    n_state   = wrcc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wrcc_pkg::S_IDLE;
            end
        endcase
    end

    assign n_rv   = ram_re;
    assign n_pv   = r_rv;
    assign n_pval = ram_rdata;
    assign n_prod = 34'(ram_rdata) * 34'(ram_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wrcc_pkg::S_IDLE;
            r_held  <= '0;
            r_wslot <= '0;
            r_latch <= 1'b0;
            r_oval  <= 1'b0;
            r_rv    <= 1'b0;
            r_pv    <= 1'b0;
            r_wl    <= wrcc_pkg::WL_RESET;
            r_thr   <= wrcc_pkg::THR_RESET;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            r_wslot <= n_wslot;
            r_latch <= n_latch;
            r_oval  <= n_oval;
            r_rv    <= n_rv;
            r_pv    <= n_pv;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    wrcc_pkg::CFG_WINDOW_LENGTH: r_wl  <= i_cfg_data[6:0];
                    wrcc_pkg::CFG_CV_THRESHOLD:  r_thr <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero    <= n_zero;
        r_ratio   <= n_ratio;
        r_ridx    <= n_ridx;
        r_issue   <= n_issue;
        r_pval    <= n_pval;
        r_prod    <= n_prod;
        r_sum     <= n_sum;
        r_sq      <= n_sq;
        r_s2      <= n_s2;
        r_nq      <= n_nq;
        r_pstatus <= n_pstatus;
        r_pcv     <= n_pcv;
        r_ostatus <= n_ostatus;
        r_ocv     <= n_ocv;
        r_oratio  <= n_oratio;
        r_oconv   <= n_oconv;
    end

    assign o_out_valid    = r_oval;
    assign o_status       = r_ostatus;
    assign o_cv_ratio     = r_ocv;
    assign o_newest_ratio = r_oratio;
    assign o_converged    = r_oconv;

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
`default_nettype none
module tb_top;

    localparam int WIN_MAX   = 64;
    localparam int DRAIN_CYC = 300;    // extra wait once all predictions are matched
    localparam int STALL_LIM = 20000;  // cycles without any beat or register write
    localparam int HOLD_CYC  = 1500;   // one long receiver hold-off

    typedef struct packed {
        logic [31:0] bound;
        logic [31:0] exited;
        logic [31:0] tmo;
    } t_counts;

    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] cv;
        logic [16:0] newest;
        logic        conv;
    } t_cv_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = wrcc_pkg::CFG_WINDOW_LENGTH;
    logic [23:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [31:0] i_bound_count = '0;
    logic [31:0] i_exited_count = '0;
    logic [31:0] i_timeout_count = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_status;
    logic [23:0] o_cv_ratio;
    logic [16:0] o_newest_ratio;
    logic        o_converged;

    window_ratio_convergence_check_unit #(.WINDOW_MAX(WIN_MAX)) DUT (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // shadow of the block: window, fill level, write pointer, sticky flag, registers
    logic [16:0] ratio_hist [WIN_MAX];
    int          hist_count = 0;
    int          hist_wr    = 0;
    logic        conv_flag  = 1'b0;
    logic [6:0]  win_len_reg = wrcc_pkg::WL_RESET;
    logic [23:0] thr_reg     = wrcc_pkg::THR_RESET;

    t_counts     beats_todo [$];
    t_cv_result  cv_expected [$];
    int          errors = 0;
    int          n_in = 0, n_out = 0, n_valid = 0, n_meanzero = 0;
    int          snd_idle_pct = 0, rcv_stall_pct = 0;
    bit          hold_go = 0, hold_done = 0;
    int          hold_left = 0;
    bit          in_taken = 0;
    int          quiet_cyc = 0;

    logic [6:0]  wl_set  [6] = '{7'd16, 7'd1, 7'd0, 7'd127, 7'd64, 7'd5};
    logic [23:0] thr_set [6] = '{24'd655, 24'd0, 24'hFFFFFF, 24'd2000, 24'd1, 24'd655};

    function automatic logic [16:0] bound_fraction(input t_counts c);
        longint unsigned tot;
        tot = longint'(c.bound) + longint'(c.exited) + longint'(c.tmo);
        if (tot == 0) return '0;
        return 17'(((longint'(c.bound) << 17) + tot) / (tot << 1));
    endfunction

    // updates the shadow window and returns the result the block should give
    function automatic t_cv_result predict_cv(input t_counts c);
        t_cv_result      r;
        longint unsigned sum, sq, s2, d, q, root, v;
        logic [127:0]    num;
        int              len, idx;
        r = '0;
        r.newest = bound_fraction(c);
        len = (win_len_reg == 0) ? 1 : (win_len_reg > WIN_MAX) ? WIN_MAX : int'(win_len_reg);
        ratio_hist[hist_wr] = r.newest;
        hist_wr = (hist_wr + 1) % WIN_MAX;
        hist_count = (hist_count + 1 < len) ? hist_count + 1 : len;
        r.status = wrcc_pkg::STATUS_NOT_FULL;
        if (hist_count >= len) begin
            sum = 0;
            sq = 0;
            idx = hist_wr;
            for (int k = 0; k < hist_count; k++) begin
                idx = (idx == 0) ? WIN_MAX - 1 : idx - 1;
                v = ratio_hist[idx];
                sum += v;
                sq += v * v;
            end
            if (sum == 0) begin
                r.status = wrcc_pkg::STATUS_MEAN_ZERO;
            end else begin
                s2 = sum * sum;
                d = longint'(hist_count) * sq;
                d = (d >= s2) ? d - s2 : 0;
                num = {64'd0, d} << 32;
                q = 64'(num / s2);
                root = 0;
                for (int k = 24; k >= 0; k--) begin
                    v = root | (64'd1 << k);
                    if (v * v <= q) root = v;
                end
                r.cv = (root > 64'hFFFFFF) ? 24'hFFFFFF : 24'(root);
                r.status = wrcc_pkg::STATUS_VALID;
                if (r.cv != 0 && r.cv <= thr_reg) conv_flag = 1'b1;
            end
        end
        r.conv = conv_flag;
        return r;
    endfunction

    // input side: take the beat, predict, then offer the next one at the falling edge
    always @(posedge i_clk) begin
        in_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (in_taken) begin
            cv_expected.insert(cv_expected.size(),
                               predict_cv({i_bound_count, i_exited_count, i_timeout_count}));
            n_in++;
        end
    end

    always @(negedge i_clk) begin
        t_counts c;
        if (!i_in_valid || in_taken) begin
            if (beats_todo.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                c = beats_todo[0];
                beats_todo.delete(0);
                i_in_valid      <= 1'b1;
                i_bound_count   <= c.bound;
                i_exited_count  <= c.exited;
                i_timeout_count <= c.tmo;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall, plus one long hold-off so the block backs up its input
    always @(negedge i_clk) begin
        if (hold_go && !hold_done) begin
            hold_done = 1;
            hold_left = HOLD_CYC;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rcv_stall_pct);
        end
    end

    // output monitor: compare each beat with the oldest prediction
    always @(posedge i_clk) begin
        t_cv_result e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_out++;
            if (cv_expected.size() == 0) begin
                $error("result beat with no prediction pending");
                errors++;
            end else begin
                e = cv_expected[0];
                cv_expected.delete(0);
                if (e.status == wrcc_pkg::STATUS_VALID) n_valid++;
                if (e.status == wrcc_pkg::STATUS_MEAN_ZERO) n_meanzero++;
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status);
                    errors++;
                end
                if (o_cv_ratio !== e.cv) begin
                    $error("cv_ratio exp %0h got %0h", e.cv, o_cv_ratio);
                    errors++;
                end
                if (o_newest_ratio !== e.newest) begin
                    $error("newest_ratio exp %0h got %0h", e.newest, o_newest_ratio);
                    errors++;
                end
                if (o_converged !== e.conv) begin
                    $error("converged exp %0b got %0b", e.conv, o_converged);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no traffic at all
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
            quiet_cyc <= 0;
        else
            quiet_cyc <= quiet_cyc + 1;
        if (quiet_cyc >= STALL_LIM) begin
            $display("watchdog: no progress, %0d predictions left", cv_expected.size());
            $display("** window_ratio_convergence_check_unit: FAILED **");
            $finish;
        end
    end

    task automatic reg_write(input logic idx, input logic [23:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == wrcc_pkg::CFG_WINDOW_LENGTH) win_len_reg = val[6:0];
        else thr_reg = val;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (beats_todo.size() != 0 || cv_expected.size() != 0 || i_in_valid);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic queue_beat(input t_counts c);
        beats_todo.insert(beats_todo.size(), c);
    endtask

    function automatic t_counts rand_counts();
        t_counts c;
        int      mode;
        logic [31:0] base;
        mode = $urandom_range(9);
        base = $urandom_range(1, 5000);
        case (mode)
            0, 1, 2, 3: begin   // steady binding rate with light jitter: converging run
                c.bound  = base * 7 + $urandom_range(0, 3);
                c.exited = base * 3;
                c.tmo    = base;
            end
            4, 5: begin         // exactly steady rate
                c = {32'd700, 32'd300, 32'd100};
            end
            6: c = {$urandom(), $urandom(), $urandom()};
            7: c = {$urandom_range(0, 1) ? 32'hFFFFFFFF : 32'd0,
                    $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'd0,
                    $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'd0};
            8: c = {32'd0, $urandom(), $urandom_range(0, 3)};
            default: c = {$urandom_range(0, 20), $urandom_range(0, 20), $urandom_range(0, 20)};
        endcase
        return c;
    endfunction

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: small window, mean-zero window, extremes, rounding tie
        reg_write(wrcc_pkg::CFG_WINDOW_LENGTH, 24'd4);
        reg_write(wrcc_pkg::CFG_CV_THRESHOLD, wrcc_pkg::THR_RESET);
        repeat (4) queue_beat({32'd0, 32'd5, 32'd9});
        queue_beat({32'd0, 32'd0, 32'd0});
        queue_beat({32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF});
        queue_beat({32'hFFFFFFFF, 32'd0, 32'd0});
        queue_beat({32'd1, 32'd131071, 32'd0});
        queue_beat({32'd1, 32'd0, 32'd131071});
        queue_beat({32'd1, 32'hFFFFFFFF, 32'hFFFFFFFF});
        repeat (4) queue_beat({32'd500, 32'd500, 32'd0});
        repeat (4) queue_beat({32'd500 + 32'($urandom_range(1, 2)), 32'd500, 32'd1});
        queue_beat({32'h55555555, 32'hAAAAAAAA, 32'h0F0F0F0F});
        queue_beat({32'hAAAAAAAA, 32'h55555555, 32'hF0F0F0F0});
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            snd_idle_pct  = (ph < 2) ? 7 : (ph < 4) ? 82 : 0;
            rcv_stall_pct = (ph < 2) ? 82 : (ph < 4) ? 7 : 0;
            // window_length lives in the low bits; upper data bits are ignored
            reg_write(wrcc_pkg::CFG_WINDOW_LENGTH, {17'($urandom()), wl_set[ph]});
            reg_write(wrcc_pkg::CFG_CV_THRESHOLD, thr_set[ph]);
            for (int k = 0; k < 200; k++) queue_beat(rand_counts());
            if (ph == 4) hold_go = 1;
            wait_idle();
        end

        $display("covered %0d beats in, %0d out (%0d valid cv, %0d zero-mean windows)",
                 n_in, n_out, n_valid, n_meanzero);
        $display("window lengths 0..127 incl. shrink/grow, thresholds 0..max, converged=%0b",
                 conv_flag);
        if (errors == 0 && cv_expected.size() == 0)
            $display("** window_ratio_convergence_check_unit: PASSED **");
        else
            $display("** window_ratio_convergence_check_unit: FAILED **");
        $finish;
    end

endmodule
`default_nettype wire
